[src/prop_pkg.sv]
// prop_pkg: item types, drawing mode codes, register indexes and stage
// feature struct for the pixel raster op unit
// no dependencies
package prop_pkg;

  localparam int ChanW = 8;
  localparam int SumW  = 10;
  localparam int CfgW  = 32;
  localparam int IdxW  = 2;

  localparam logic [ChanW-1:0] ChanMax   = 8'd255;
  localparam logic [ChanW-1:0] AlphaHalf = 8'd127;

  localparam logic [3:0] MODE_COPY     = 4'd0;
  localparam logic [3:0] MODE_OVER     = 4'd1;
  localparam logic [3:0] MODE_ERASE    = 4'd2;
  localparam logic [3:0] MODE_INVERT   = 4'd3;
  localparam logic [3:0] MODE_ADD      = 4'd4;
  localparam logic [3:0] MODE_SUBTRACT = 4'd5;
  localparam logic [3:0] MODE_BLEND    = 4'd6;
  localparam logic [3:0] MODE_MIN      = 4'd7;
  localparam logic [3:0] MODE_MAX      = 4'd8;
  localparam logic [3:0] MODE_SELECT   = 4'd9;
  localparam logic [3:0] MODE_ALPHA    = 4'd10;

  localparam logic [IdxW-1:0] REG_ROP_MODE   = 2'd0;
  localparam logic [IdxW-1:0] REG_HIGH_COLOR = 2'd1;
  localparam logic [IdxW-1:0] REG_LOW_COLOR  = 2'd2;

  typedef struct packed {
    logic [ChanW-1:0] src_red;
    logic [ChanW-1:0] src_green;
    logic [ChanW-1:0] src_blue;
    logic [ChanW-1:0] src_alpha;
    logic [ChanW-1:0] dst_red;
    logic [ChanW-1:0] dst_green;
    logic [ChanW-1:0] dst_blue;
    logic [ChanW-1:0] dst_alpha;
    logic             pick_high;
  } in_item_t;

  typedef struct packed {
    logic [ChanW-1:0] out_red;
    logic [ChanW-1:0] out_green;
    logic [ChanW-1:0] out_blue;
    logic [ChanW-1:0] out_alpha;
  } out_item_t;

  typedef struct packed {
    logic [SumW-1:0]  ssum;
    logic [SumW-1:0]  dsum;
    logic             pen;
    logic             src_hi;
    logic             src_lo;
    logic             dst_hi;
    logic             dst_lo;
    logic [ChanW:0]   add_red;
    logic [ChanW:0]   add_green;
    logic [ChanW:0]   add_blue;
    logic [ChanW:0]   sub_red;
    logic [ChanW:0]   sub_green;
    logic [ChanW:0]   sub_blue;
  } feat_t;

endpackage

[src/prop_feat.sv]
// prop_feat: first compute stage, channel sums, differences, pen and
// color matches from one input item; uses prop_pkg
module prop_feat
  import prop_pkg::*;
(
  input  in_item_t        item,
  input  logic [CfgW-1:0] high_color,
  input  logic [CfgW-1:0] low_color,
  output feat_t           feat
);

  logic [CfgW-1:0] src_px;
  logic [CfgW-1:0] dst_px;

  assign src_px = {item.src_red, item.src_green, item.src_blue, item.src_alpha};
  assign dst_px = {item.dst_red, item.dst_green, item.dst_blue, item.dst_alpha};

  always_comb begin
    feat.ssum = {2'b00, item.src_red} + {2'b00, item.src_green}
              + {2'b00, item.src_blue};
    feat.dsum = {2'b00, item.dst_red} + {2'b00, item.dst_green}
              + {2'b00, item.dst_blue};
    feat.pen    = item.pick_high && (item.src_alpha > AlphaHalf);
    feat.src_hi = (src_px == high_color);
    feat.src_lo = (src_px == low_color);
    feat.dst_hi = (dst_px == high_color);
    feat.dst_lo = (dst_px == low_color);
    feat.add_red   = {1'b0, item.src_red}   + {1'b0, item.dst_red};
    feat.add_green = {1'b0, item.src_green} + {1'b0, item.dst_green};
    feat.add_blue  = {1'b0, item.src_blue}  + {1'b0, item.dst_blue};
    feat.sub_red   = {1'b0, item.src_red}   - {1'b0, item.dst_red};
    feat.sub_green = {1'b0, item.src_green} - {1'b0, item.dst_green};
    feat.sub_blue  = {1'b0, item.src_blue}  - {1'b0, item.dst_blue};
  end

endmodule

[src/prop_mux.sv]
// prop_mux: second compute stage, forms the result pixel per drawing mode
// from the item and its features; uses prop_pkg
module prop_mux
  import prop_pkg::*;
(
  input  in_item_t        item,
  input  feat_t           feat,
  input  logic [3:0]      rop_mode,
  input  logic [CfgW-1:0] high_color,
  input  logic [CfgW-1:0] low_color,
  output out_item_t       result
);

  out_item_t src_o;
  out_item_t dst_o;

  function automatic logic [ChanW-1:0] sat_add(input logic [ChanW:0] v);
    return v[ChanW] ? ChanMax : v[ChanW-1:0];
  endfunction

  function automatic logic [ChanW-1:0] clip_sub(input logic [ChanW:0] v);
    return v[ChanW] ? '0 : v[ChanW-1:0];
  endfunction

  assign src_o = {item.src_red, item.src_green, item.src_blue, item.src_alpha};
  assign dst_o = {item.dst_red, item.dst_green, item.dst_blue, item.dst_alpha};

  always_comb begin
    result = '0;
    case (rop_mode)
      MODE_COPY, MODE_ALPHA: begin
        result = src_o;
      end
      MODE_ADD: begin
        result = {sat_add(feat.add_red), sat_add(feat.add_green),
                  sat_add(feat.add_blue), {ChanW{1'b0}}};
      end
      MODE_SUBTRACT: begin
        result = {clip_sub(feat.sub_red), clip_sub(feat.sub_green),
                  clip_sub(feat.sub_blue), {ChanW{1'b0}}};
      end
      MODE_BLEND: begin
        result = {feat.add_red[ChanW:1], feat.add_green[ChanW:1],
                  feat.add_blue[ChanW:1], {ChanW{1'b0}}};
      end
      MODE_MIN: begin
        result = (feat.ssum > feat.dsum) ? dst_o : src_o;
      end
      MODE_MAX: begin
        result = (feat.ssum < feat.dsum) ? dst_o : src_o;
      end
      MODE_OVER: begin
        result = feat.pen ? src_o : dst_o;
      end
      MODE_INVERT: begin
        if (feat.pen) begin
          result = {item.dst_red ^ ChanMax, item.dst_green ^ ChanMax,
                    item.dst_blue ^ ChanMax, {ChanW{1'b0}}};
        end else begin
          result = dst_o;
        end
      end
      MODE_ERASE: begin
        result = feat.pen ? out_item_t'(low_color) : dst_o;
      end
      MODE_SELECT: begin
        if (feat.src_hi) begin
          result = (item.pick_high && feat.dst_hi) ? out_item_t'(low_color) : dst_o;
        end else if (feat.src_lo) begin
          result = (item.pick_high && feat.dst_lo) ? out_item_t'(high_color) : dst_o;
        end else begin
          result = dst_o;
        end
      end
      default: begin
        result = '0;
      end
    endcase
  end

endmodule

[src/pixel_raster_op_unit.sv]
// pixel_raster_op_unit: top level, config registers and three-stage
// pipeline; uses prop_pkg, prop_feat and prop_mux
//
//   channel | signals                              | accepted when
//   in      | in_valid, in_ready, in_item          | in_valid && in_ready
//   out     | out_valid, out_ready, out_item       | out_valid && out_ready
//   cfg     | cfg_we, cfg_index, cfg_data          | cfg_we
//
// three register stages: input capture, features, result
// one item per cycle sustained while out_ready stays high
// each stage advances when it is empty or the next one takes its item
// rst clears valid bits and config registers to zero
module pixel_raster_op_unit
  import prop_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  in_item_t        in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output out_item_t       out_item,
  input  logic            cfg_we,
  input  logic [IdxW-1:0] cfg_index,
  input  logic [CfgW-1:0] cfg_data
);

  logic [3:0]      rop_mode;
  logic [CfgW-1:0] high_color;
  logic [CfgW-1:0] low_color;

  logic      v1;
  logic      v2;
  in_item_t  item1;
  in_item_t  item2;
  feat_t     feat2;
  feat_t     feat_next;
  out_item_t result_next;
  logic      ready2;
  logic      ready3;

  always_ff @(posedge clk) begin
    if (rst) begin
      rop_mode   <= MODE_COPY;
      high_color <= '0;
      low_color  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROP_MODE:   rop_mode   <= cfg_data[3:0];
        REG_HIGH_COLOR: high_color <= cfg_data;
        REG_LOW_COLOR:  low_color  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign ready3   = !out_valid || out_ready;
  assign ready2   = !v2 || ready3;
  assign in_ready = !v1 || ready2;

  prop_feat u_feat (
    .item       (item1),
    .high_color (high_color),
    .low_color  (low_color),
    .feat       (feat_next)
  );

  prop_mux u_mux (
    .item       (item2),
    .feat       (feat2),
    .rop_mode   (rop_mode),
    .high_color (high_color),
    .low_color  (low_color),
    .result     (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        v1 <= in_valid;
      end
      if (ready2) begin
        v2 <= v1;
      end
      if (ready3) begin
        out_valid <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item1 <= in_item;
    end
    if (ready2 && v1) begin
      item2 <= item1;
      feat2 <= feat_next;
    end
    if (ready3 && v2) begin
      out_item <= result_next;
    end
  end

endmodule

[src/prop_check.sv]
// prop_check: port-level checks for pixel_raster_op_unit and its bind
// uses prop_pkg
module prop_check
  import prop_pkg::*;
(
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input out_item_t       out_item
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result item present right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("stalled result item changed or dropped");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input not ready while output stage is empty");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !out_valid && !in_valid ##1 !out_valid && !in_valid ##1 !out_valid
    |=> !out_valid)
    else $error("result item appeared with no item in flight");

endmodule

bind pixel_raster_op_unit prop_check u_check (.*);
